// ----- rtl/core/dwss_pkg.sv -----
// ----------------------------------------------------------------------------
// dwss_pkg
// Shared types and constants for the delayed work slot scheduler: table size,
// field widths, command and status codes, and the transaction payloads.
// ----------------------------------------------------------------------------
package dwss_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int ID_BITS      = 8;
    localparam int SLOT_IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int CMD_W        = 3;
    localparam int WORK_ID_W    = 8;
    localparam int TICKS_W      = 32;
    localparam int STATUS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_SUBMIT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FETCH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

    localparam logic [TICKS_W-1:0] DELAY_INVALID = '1;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [WORK_ID_W-1:0] work_id;
        logic [TICKS_W-1:0]   start_delay;
        logic [TICKS_W-1:0]   tick_span;
    } dwss_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 wake;
        logic                 fetched_valid;
        logic [WORK_ID_W-1:0] fetched_id;
        logic                 id_held;
        logic                 any_ready;
    } dwss_out_t;

endpackage

// ----- rtl/core/delayed_work_slot_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// delayed_work_slot_scheduler_unit
// Slot table of delayed work items with submit, cancel, tick, fetch and query
// commands, served by a sequencer that walks the slots one per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_payload carry one command transaction; m_valid/m_ready/
//   m_payload return exactly one result transaction for each command.
//   Submit, cancel, tick, fetch and query walk all SLOT_COUNT slots through one
//   shared match/subtract unit, one slot per cycle, then update the addressed
//   slot in ST_APPLY and post the result in ST_FINISH. An invalid delay, a
//   tick of zero elapsed ticks and an unknown command skip the walk and
//   ST_APPLY and go straight to ST_FINISH to post their result.
//   One command is in flight at a time; s_ready is high only while the
//   sequencer is idle, so a new command is taken only after the last one
//   has posted its result.
//   A posted result sits in the output register, and the next command is
//   taken while it waits; if the receiver stalls, a finished command holds
//   its result until the output register frees up.
//   Reset (aresetn low, synchronous) frees every slot, drops any result and
//   returns the sequencer to idle.
// ----------------------------------------------------------------------------
module delayed_work_slot_scheduler_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dwss_pkg::dwss_in_t s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output dwss_pkg::dwss_out_t m_payload
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_APPLY  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef logic [dwss_pkg::SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [dwss_pkg::SLOT_COUNT-1:0] slot_vec_t;

    state_t state_reg, state_next;

    // slot table
    slot_vec_t                            used_reg, used_next;
    slot_vec_t                            waiting_reg, waiting_next;
    slot_vec_t                            runnable_reg, runnable_next;
    logic [dwss_pkg::ID_BITS-1:0]         item_reg [dwss_pkg::SLOT_COUNT];
    logic [dwss_pkg::TICKS_W-1:0]         count_reg [dwss_pkg::SLOT_COUNT];

    // command in flight
    logic [dwss_pkg::CMD_W-1:0]   cmd_reg;
    logic [dwss_pkg::ID_BITS-1:0] id_reg;
    logic [dwss_pkg::TICKS_W-1:0] delay_reg;
    logic [dwss_pkg::TICKS_W-1:0] elapsed_reg;

    slot_idx_t scan_idx_reg, scan_idx_next;
    logic      hit_reg, hit_next;
    slot_idx_t hit_idx_reg, hit_idx_next;
    logic      free_reg, free_next;
    slot_idx_t free_idx_reg, free_idx_next;

    dwss_pkg::dwss_out_t res_reg, res_next;
    dwss_pkg::dwss_out_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    // slot write port
    logic                         item_we;
    slot_idx_t                    item_idx;
    logic [dwss_pkg::ID_BITS-1:0] item_wdata;
    logic                         count_we;
    slot_idx_t                    count_idx;
    logic [dwss_pkg::TICKS_W-1:0] count_wdata;

    // shared match/subtract unit
    logic                         cur_used;
    logic                         cur_waiting;
    logic                         cur_runnable;
    logic                         cur_match;
    logic [dwss_pkg::TICKS_W:0]   diff;
    logic                         expire;
    logic                         scan_last;
    logic                         accept;
    logic                         out_free;
    logic                         hit_live;
    slot_idx_t                    tgt_idx;
    logic [dwss_pkg::ID_BITS-1:0] in_id;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;
    assign out_free  = !out_valid_reg || m_ready;
    assign in_id     = dwss_pkg::ID_BITS'(s_payload.work_id);

    assign cur_used     = used_reg[scan_idx_reg];
    assign cur_waiting  = waiting_reg[scan_idx_reg];
    assign cur_runnable = runnable_reg[scan_idx_reg];
    assign cur_match    = cur_used && (item_reg[scan_idx_reg] == id_reg);
    assign diff         = {1'b0, count_reg[scan_idx_reg]} - {1'b0, elapsed_reg};
    assign expire       = diff[dwss_pkg::TICKS_W] || (diff[dwss_pkg::TICKS_W-1:0] == '0);
    assign scan_last    = (scan_idx_reg == slot_idx_t'(dwss_pkg::SLOT_COUNT - 1));
    assign hit_live     = hit_reg && (waiting_reg[hit_idx_reg] || runnable_reg[hit_idx_reg]);
    assign tgt_idx      = hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        waiting_next   = waiting_reg;
        runnable_next  = runnable_reg;
        scan_idx_next  = scan_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        item_we        = 1'b0;
        item_idx       = tgt_idx;
        item_wdata     = id_reg;
        count_we       = 1'b0;
        count_idx      = scan_idx_reg;
        count_wdata    = diff[dwss_pkg::TICKS_W-1:0];

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next      = '0;
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    state_next    = ST_SCAN;
                    case (s_payload.command)
                        dwss_pkg::CMD_SUBMIT: begin
                            if (s_payload.start_delay == dwss_pkg::DELAY_INVALID) begin
                                res_next.status = dwss_pkg::STATUS_INVALID;
                                state_next      = ST_FINISH;
                            end
                        end
                        dwss_pkg::CMD_TICK: begin
                            if (s_payload.tick_span == '0) begin
                                state_next = ST_FINISH;
                            end
                        end
                        dwss_pkg::CMD_CANCEL, dwss_pkg::CMD_FETCH,
                        dwss_pkg::CMD_QUERY: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            res_next.status = dwss_pkg::STATUS_INVALID;
                            state_next      = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (cmd_reg == dwss_pkg::CMD_FETCH) begin
                    if (cur_used && cur_runnable && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = scan_idx_reg;
                    end
                end else if (cur_match && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_idx_reg;
                end
                if (!cur_used && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = scan_idx_reg;
                end
                if (cmd_reg == dwss_pkg::CMD_TICK && cur_used && cur_waiting) begin
                    count_we = 1'b1;
                    if (expire) begin
                        count_wdata                 = '0;
                        waiting_next[scan_idx_reg]  = 1'b0;
                        runnable_next[scan_idx_reg] = 1'b1;
                        res_next.wake               = 1'b1;
                    end
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_last) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                state_next = ST_FINISH;
                case (cmd_reg)
                    dwss_pkg::CMD_SUBMIT: begin
                        if (!hit_reg && !free_reg) begin
                            res_next.status = dwss_pkg::STATUS_FULL;
                        end else begin
                            item_we                = 1'b1;
                            count_we               = 1'b1;
                            count_idx              = tgt_idx;
                            count_wdata            = delay_reg;
                            used_next[tgt_idx]     = 1'b1;
                            waiting_next[tgt_idx]  = (delay_reg != '0);
                            runnable_next[tgt_idx] = (delay_reg == '0);
                            res_next.wake          = (delay_reg == '0);
                        end
                    end
                    dwss_pkg::CMD_CANCEL: begin
                        if (!hit_live) begin
                            res_next.status = dwss_pkg::STATUS_EMPTY;
                        end
                        if (hit_reg) begin
                            used_next[hit_idx_reg]     = 1'b0;
                            waiting_next[hit_idx_reg]  = 1'b0;
                            runnable_next[hit_idx_reg] = 1'b0;
                        end
                    end
                    dwss_pkg::CMD_FETCH: begin
                        if (hit_reg) begin
                            res_next.fetched_valid     = 1'b1;
                            res_next.fetched_id        =
                                dwss_pkg::WORK_ID_W'(item_reg[hit_idx_reg]);
                            used_next[hit_idx_reg]     = 1'b0;
                            waiting_next[hit_idx_reg]  = 1'b0;
                            runnable_next[hit_idx_reg] = 1'b0;
                        end
                    end
                    dwss_pkg::CMD_QUERY: begin
                        res_next.id_held = hit_live;
                    end
                    default: begin
                        res_next = res_reg;
                    end
                endcase
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next           = res_reg;
                    out_next.any_ready = |(used_reg & runnable_reg);
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            waiting_reg   <= '0;
            runnable_reg  <= '0;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            waiting_reg   <= waiting_next;
            runnable_reg  <= runnable_next;
            out_valid_reg <= out_valid_next;
            scan_idx_reg  <= scan_idx_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        if (accept) begin
            cmd_reg     <= s_payload.command;
            id_reg      <= in_id;
            delay_reg   <= s_payload.start_delay;
            elapsed_reg <= s_payload.tick_span;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_we) begin
            item_reg[item_idx] <= item_wdata;
        end
        if (count_we) begin
            count_reg[count_idx] <= count_wdata;
        end
    end

`ifndef SYNTH
    a_used_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ((used_reg & ~(waiting_reg | runnable_reg)) == '0))
        else $error("used slot without waiting or runnable mark");

    a_marks_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        ((waiting_reg & runnable_reg) == '0))
        else $error("slot both waiting and runnable");

    a_marks_in_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (((waiting_reg | runnable_reg) & ~used_reg) == '0))
        else $error("mark set on free slot");

    a_fetch_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.fetched_valid) |->
            (out_reg.status == dwss_pkg::STATUS_OK && !out_reg.wake))
        else $error("fetch result with bad status or wake");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("new transaction taken while one is in flight");
`endif

endmodule
